### rtl/mbe_pkg.sv
// Package for the Mandelbrot escape-time block: constants, register and
// sequencer codes, and the saturate and magnitude helpers.
// No dependencies.
package mbe_pkg;

  localparam int FRAC_BITS      = 60;
  localparam int COORD_BITS_DEF = 12;
  localparam int ITER_W         = 16;
  localparam int ADDR_W         = 6;
  localparam int DATA_W         = 64;

  // |z|^2 reaches 4.0 once any bit at or above this position is set
  localparam int FOUR_BIT = 2 * FRAC_BITS + 2;

  localparam logic [ITER_W-1:0]  MAX_ITER_RST = 16'd256;
  localparam logic signed [63:0] SCALE_RST    = 64'sd5764607523034235;
  localparam logic signed [63:0] CENTER_X_RST = -64'sd576460752303423488;
  localparam logic signed [63:0] CENTER_Y_RST = 64'sd0;
  localparam int                 WIDTH_RST    = 640;
  localparam int                 HEIGHT_RST   = 480;

  typedef enum logic [2:0] {
    REG_MAX_ITER,
    REG_SCALE_X,
    REG_SCALE_Y,
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_LOOP,
    S_TEST,
    S_UPD,
    S_DONE
  } state_t;

  // which product the shared multiplier is forming
  typedef enum logic [2:0] {
    J_MAP_X,
    J_MAP_Y,
    J_RR,
    J_II,
    J_RI
  } job_t;

  function automatic logic signed [63:0] sat64(input logic signed [127:0] v);
    logic fits;
    fits = (&v[127:63]) || !(|v[127:63]);
    if (fits) begin
      return v[63:0];
    end else if (v[127]) begin
      return 64'sh8000_0000_0000_0000;
    end else begin
      return 64'sh7FFF_FFFF_FFFF_FFFF;
    end
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

endpackage

### rtl/mbe_in_if.sv
// Pixel request channel: valid/ready handshake with the pixel coordinate.
// Depends on mbe_pkg.
interface mbe_in_if import mbe_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;

  modport source(output valid, pixel_x, pixel_y, input ready);
  modport sink(input valid, pixel_x, pixel_y, output ready);
endinterface

### rtl/mbe_out_if.sv
// Result channel: valid/ready handshake with step count and in-set flag.
// Depends on mbe_pkg.
interface mbe_out_if import mbe_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ITER_W-1:0] iter_count;
  logic              in_set;

  modport source(output valid, iter_count, in_set, input ready);
  modport sink(input valid, iter_count, in_set, output ready);
endinterface

### rtl/mandelbrot_escape_time.sv
// Mandelbrot escape-time evaluator: maps a pixel to c and iterates z = z*z + c
// on one shared 32x32 multiplier. Depends on mbe_pkg, mbe_in_if, mbe_out_if.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+-------------------------------
//   pixel   | in  | valid/ready        | pixel_x, pixel_y
//   result  | out | valid/ready        | iter_count, in_set
//   apb     | in  | psel/penable/pready| paddr, pwdata, prdata (64 bit)
//
// A 64x64 product is built from four 32x32 partial products, each registered
// and then added into a 128-bit accumulator. Mapping forms two products and
// each full iteration three (plus the loop, escape test and update states).
// The result shows when the limit n is reached, when z escapes after n steps,
// or when step n + 1 finds a fixed point. One pixel is in flight at a time;
// pixel.ready is low until the result has been taken. Reset is synchronous
// and restores the register defaults.
module mandelbrot_escape_time import mbe_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  mbe_in_if.sink            pixel,
  mbe_out_if.source         result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int CW = COORD_BITS + 1;   // image size width
  localparam int DW = COORD_BITS + 2;   // signed offset from center

  // configuration registers
  logic [ITER_W-1:0]  max_iter;
  logic signed [63:0] scale_x;
  logic signed [63:0] scale_y;
  logic signed [63:0] center_x;
  logic signed [63:0] center_y;
  logic [CW-1:0]      image_width;
  logic [CW-1:0]      image_height;

  // sequencer
  state_t state;
  state_t state_next;
  job_t   job;
  logic [2:0] cnt;

  // shared multiplier and accumulator
  logic [63:0]  opa;
  logic [63:0]  opb;
  logic         mneg;
  logic [31:0]  a_half;
  logic [31:0]  b_half;
  logic [63:0]  prod;
  logic [1:0]   prev;
  logic [6:0]   shamt;
  logic [127:0] addend;
  logic [127:0] acc;
  logic [127:0] acc_sum;

  // pixel mapping
  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic [DW-1:0]        dx_mag;
  logic [DW-1:0]        dy_mag;
  logic [DW-1:0]        dy_mag_q;
  logic                 dy_neg_q;

  // iteration state
  logic signed [63:0] cr;
  logic signed [63:0] ci;
  logic signed [63:0] r_q;
  logic signed [63:0] i_q;
  logic [ITER_W-1:0]  step;
  logic               in_set_q;
  logic [127:0]       rr_q;
  logic [127:0]       ii_q;
  logic [127:0]       diff_q;
  logic [127:0]       sum;
  logic [127:0]       diff;
  logic               escape;
  logic signed [127:0] nr_wide;
  logic signed [127:0] ni_wide;
  logic signed [63:0]  nr;
  logic signed [63:0]  ni;
  logic                fixed_pt;
  logic                mul_end;

  logic     cfg_wr;
  reg_idx_t cfg_idx;

  // ---------------------------------------------------------------- config
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iter     <= MAX_ITER_RST;
      scale_x      <= SCALE_RST;
      scale_y      <= SCALE_RST;
      center_x     <= CENTER_X_RST;
      center_y     <= CENTER_Y_RST;
      image_width  <= CW'(WIDTH_RST);
      image_height <= CW'(HEIGHT_RST);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MAX_ITER:     max_iter     <= pwdata[ITER_W-1:0];
        REG_SCALE_X:      scale_x      <= pwdata;
        REG_SCALE_Y:      scale_y      <= pwdata;
        REG_CENTER_X:     center_x     <= pwdata;
        REG_CENTER_Y:     center_y     <= pwdata;
        REG_IMAGE_WIDTH:  image_width  <= pwdata[CW-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MAX_ITER:     prdata = {{(DATA_W-ITER_W){1'b0}}, max_iter};
      REG_SCALE_X:      prdata = scale_x;
      REG_SCALE_Y:      prdata = scale_y;
      REG_CENTER_X:     prdata = center_x;
      REG_CENTER_Y:     prdata = center_y;
      REG_IMAGE_WIDTH:  prdata = {{(DATA_W-CW){1'b0}}, image_width};
      REG_IMAGE_HEIGHT: prdata = {{(DATA_W-CW){1'b0}}, image_height};
      default:          prdata = '0;
    endcase
  end

  // ------------------------------------------------------------ mapping
  assign dx = $signed({2'b00, pixel.pixel_x}) - $signed({2'b00, image_width[CW-1:1]});
  assign dy = $signed({2'b00, pixel.pixel_y}) - $signed({2'b00, image_height[CW-1:1]});
  assign dx_mag = dx[DW-1] ? (~dx + 1'b1) : dx;
  assign dy_mag = dy[DW-1] ? (~dy + 1'b1) : dy;

  // --------------------------------------------------------- multiplier
  assign a_half = cnt[1] ? opa[63:32] : opa[31:0];
  assign b_half = cnt[0] ? opb[63:32] : opb[31:0];

  // partial product formed last cycle
  assign prev = cnt[1:0] - 2'd1;

  always_comb begin
    unique case (prev)
      2'd0:    shamt = 7'd0;
      2'd1:    shamt = 7'd32;
      2'd2:    shamt = 7'd32;
      default: shamt = 7'd64;
    endcase
  end

  assign addend  = {64'd0, prod} << shamt;
  assign acc_sum = acc + (mneg ? ~addend : addend) + {127'd0, mneg};
  assign mul_end = (state == S_MUL) && (cnt == 3'd4);

  // ---------------------------------------------------- test and update
  assign sum      = rr_q + ii_q;
  assign diff     = rr_q - ii_q;
  assign escape   = |sum[127:FOUR_BIT];
  // keep both terms signed so the shift fills with the sign bit
  assign nr_wide  = ($signed(diff_q) >>> FRAC_BITS) + $signed({{64{cr[63]}}, cr});
  assign ni_wide  = ($signed({acc[126:0], 1'b0}) >>> FRAC_BITS)
                    + $signed({{64{ci[63]}}, ci});
  assign nr       = sat64(nr_wide);
  assign ni       = sat64(ni_wide);
  assign fixed_pt = (nr == r_q) && (ni == i_q);

  // ---------------------------------------------------------- sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (pixel.valid) state_next = S_MUL;
      S_MUL: begin
        if (cnt == 3'd4) begin
          unique case (job)
            J_MAP_X: state_next = S_MUL;
            J_MAP_Y: state_next = S_LOOP;
            J_RR:    state_next = S_MUL;
            J_II:    state_next = S_TEST;
            J_RI:    state_next = S_UPD;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_LOOP: state_next = (step < max_iter) ? S_MUL : S_DONE;
      S_TEST: state_next = escape ? S_DONE : S_MUL;
      S_UPD:  state_next = fixed_pt ? S_DONE : S_LOOP;
      S_DONE: if (result.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    pixel.ready       = (state == S_IDLE);
    result.valid      = (state == S_DONE);
    result.iter_count = step;
    result.in_set     = in_set_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath; each launch loads operands, sign and accumulator seed
  always_ff @(posedge clk) begin
    prod <= a_half * b_half;
    unique case (state)
      S_IDLE: begin
        if (pixel.valid) begin
          opa      <= {{(64-DW){1'b0}}, dx_mag};
          opb      <= mag64(scale_x);
          mneg     <= dx[DW-1] ^ scale_x[63];
          acc      <= {{64{center_x[63]}}, center_x};
          job      <= J_MAP_X;
          cnt      <= 3'd0;
          dy_mag_q <= dy_mag;
          dy_neg_q <= dy[DW-1];
        end
      end
      S_MUL: begin
        if (!mul_end) begin
          cnt <= cnt + 3'd1;
          if (cnt != 3'd0) acc <= acc_sum;
        end else begin
          cnt <= 3'd0;
          unique case (job)
            J_MAP_X: begin
              cr   <= sat64(acc_sum);
              opa  <= {{(64-DW){1'b0}}, dy_mag_q};
              opb  <= mag64(scale_y);
              mneg <= dy_neg_q ^ scale_y[63];
              acc  <= {{64{center_y[63]}}, center_y};
              job  <= J_MAP_Y;
            end
            J_MAP_Y: begin
              ci   <= sat64(acc_sum);
              r_q  <= '0;
              i_q  <= '0;
              step <= '0;
            end
            J_RR: begin
              rr_q <= acc_sum;
              opa  <= mag64(i_q);
              opb  <= mag64(i_q);
              mneg <= 1'b0;
              acc  <= '0;
              job  <= J_II;
            end
            J_II:    ii_q <= acc_sum;
            J_RI:    acc  <= acc_sum;
            default: ;
          endcase
        end
      end
      S_LOOP: begin
        if (step < max_iter) begin
          opa  <= mag64(r_q);
          opb  <= mag64(r_q);
          mneg <= 1'b0;
          acc  <= '0;
          job  <= J_RR;
          cnt  <= 3'd0;
        end else begin
          in_set_q <= 1'b1;
        end
      end
      S_TEST: begin
        if (escape) begin
          in_set_q <= 1'b0;
        end else begin
          diff_q <= diff;
          opa    <= mag64(r_q);
          opb    <= mag64(i_q);
          mneg   <= r_q[63] ^ i_q[63];
          acc    <= '0;
          job    <= J_RI;
          cnt    <= 3'd0;
        end
      end
      S_UPD: begin
        if (fixed_pt) begin
          step     <= max_iter;
          in_set_q <= 1'b1;
        end else begin
          r_q  <= nr;
          i_q  <= ni;
          step <= step + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------- assertions
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(pixel.ready && result.valid))
    else $error("request taken while a result is pending");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> (cnt <= 3'd4))
    else $error("partial product counter out of range");

  a_start_map: assert property (@(posedge clk) disable iff (rst)
    (pixel.valid && pixel.ready) |=> (state == S_MUL && job == J_MAP_X && cnt == 3'd0))
    else $error("accepted request did not start the mapping product");

  a_release: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.ready) |=> pixel.ready)
    else $error("block not ready after result was taken");

endmodule
